// ===== sv/pfpp_pkg.sv =====
// Shared types and constants of the page framebuffer pixel plotter.
// Used by pfpp_map, pfpp_ram users and the top level; depends on nothing.
package pfpp_pkg;

    localparam int STORE_DEPTH       = 1024;
    localparam int ADDR_W            = 10;
    // Widest mapped byte index: 256 * 7 + 255 fits in 12 bits.
    localparam int IDX_W             = 12;
    localparam int DEF_PANEL_WIDTH   = 128;
    localparam int DEF_MAX_HEIGHT    = 64;
    localparam int CFG_W             = 7;
    localparam int CFG_IDX_W         = 2;

    localparam logic [1:0] ACT_PIXEL  = 2'd0;
    localparam logic [1:0] ACT_BITMAP = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    localparam logic [1:0] COL_CLEAR  = 2'd0;
    localparam logic [1:0] COL_SET    = 2'd1;
    localparam logic [1:0] COL_TOGGLE = 2'd2;
    localparam logic [1:0] COL_KEEP   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_HEIGHT = 2'd1;

    localparam logic [6:0] HEIGHT_RESET = 7'd64;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] x_pos;
        logic signed [15:0] y_pos;
        logic [1:0]         color;
        logic [7:0]         pattern;
        logic               invert;
        logic [9:0]         read_address;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] pixels_written;
    } t_out_item;

    // One store access travelling down the update pipeline.
    typedef struct packed {
        logic             wr;
        logic             rd;
        logic [IDX_W-1:0] idx;
        logic [7:0]       mask;
        logic [1:0]       color;
    } t_pix_loc;

endpackage

// ===== sv/pfpp_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module pfpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/pfpp_map.sv =====
// Clips one logical pixel against the rotated panel and maps it to a store
// byte index and bit mask. Depends on pfpp_pkg.
module pfpp_map #(
    parameter int PANEL_WIDTH = pfpp_pkg::DEF_PANEL_WIDTH
) (
    input  logic signed [16:0] i_x,
    input  logic signed [15:0] i_y,
    input  logic [1:0]         i_color,
    input  logic [1:0]         i_rotation,
    input  logic [6:0]         i_height,
    output pfpp_pkg::t_pix_loc o_loc
);
    import pfpp_pkg::*;

    logic [8:0]       lw;
    logic [8:0]       lh;
    logic             in_x;
    logic             in_y;
    logic [8:0]       xl;
    logic [8:0]       yl;
    logic [8:0]       wm1;
    logic [8:0]       hm1;
    logic [8:0]       px;
    logic [8:0]       py;
    logic [IDX_W-1:0] idx;

    always_comb begin
        lw   = i_rotation[0] ? {2'b00, i_height} : 9'(PANEL_WIDTH);
        lh   = i_rotation[0] ? 9'(PANEL_WIDTH) : {2'b00, i_height};
        in_x = !i_x[16] && (i_x[15:0] < {7'd0, lw});
        in_y = !i_y[15] && (i_y[14:0] < {6'd0, lh});
        xl   = i_x[8:0];
        yl   = i_y[8:0];
        wm1  = 9'(PANEL_WIDTH - 1);
        hm1  = {2'b00, i_height} - 9'd1;

        case (i_rotation)
            2'd1: begin
                px = wm1 - yl;
                py = xl;
            end
            2'd2: begin
                px = wm1 - xl;
                py = hm1 - yl;
            end
            2'd3: begin
                px = yl;
                py = hm1 - xl;
            end
            default: begin
                px = xl;
                py = yl;
            end
        endcase

        idx = IDX_W'(IDX_W'(PANEL_WIDTH) * {{(IDX_W-3){1'b0}}, py[5:3]})
            + {{(IDX_W-8){1'b0}}, px[7:0]};

        o_loc.wr    = in_x && in_y && (i_color != COL_KEEP)
                   && (idx < IDX_W'(STORE_DEPTH));
        o_loc.rd    = 1'b0;
        o_loc.idx   = idx;
        o_loc.mask  = 8'd1 << py[2:0];
        o_loc.color = i_color;
    end

endmodule

// ===== sv/page_framebuffer_pixel_plotter_unit.sv =====
// Top level of the page framebuffer pixel plotter: sequencer, update pipeline
// and frame store. Depends on pfpp_pkg, pfpp_map and pfpp_ram.
//
//   channel | direction | handshake                   | payload
//   --------+-----------+-----------------------------+---------------------
//   in      | input     | i_in_valid / o_in_stall     | i_in_data  (t_in_item)
//   out     | output    | o_out_valid / i_out_stall   | o_out_data (t_out_item)
//   cfg     | input     | i_cfg_we, i_cfg_index       | i_cfg_data
//
// A bitmap byte walks its pattern one bit per cycle through the mapper and a
// two-stage read-modify-write pipeline on the store; a pixel or a read makes one
// pass through it. After reset a clearing pass writes zero to all 1024 store
// bytes, one per cycle, and no item is accepted until it ends. One item is
// worked on at a time; the next is accepted while a result is stalled in the
// output register.
module page_framebuffer_pixel_plotter_unit #(
    parameter int PANEL_WIDTH = pfpp_pkg::DEF_PANEL_WIDTH,
    parameter int MAX_HEIGHT  = pfpp_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  pfpp_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output pfpp_pkg::t_out_item               o_out_data,
    input  logic                              i_cfg_we,
    input  logic [pfpp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pfpp_pkg::CFG_W-1:0]        i_cfg_data
);
    import pfpp_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [1:0]        r_rotation;
    logic [6:0]        r_height;

    // Item being worked on.
    logic [1:0]        r_act;
    logic signed [16:0] r_x, n_x;
    logic signed [15:0] r_y;
    logic [1:0]        r_color;
    logic [7:0]        r_pat, n_pat;
    logic              r_inv;
    logic [ADDR_W-1:0] r_addr;
    logic [3:0]        r_left, n_left;
    logic [3:0]        r_cnt, n_cnt;
    logic [7:0]        r_rd, n_rd;

    // Update pipeline: stage 1 addresses the store, stage 2 writes it back.
    logic              r_s1_v, n_s1_v;
    t_pix_loc          r_s1, n_s1;
    logic              r_s2_v;
    t_pix_loc          r_s2;
    logic              r_wb_v, n_wb_v;
    logic [IDX_W-1:0]  r_wb_idx;
    logic [7:0]        r_wb_data;

    logic              r_out_v, n_out_v;
    t_out_item         r_out, n_out;

    logic [6:0]        eff_h;
    logic [1:0]        pix_color;
    t_pix_loc          map_loc;
    logic [7:0]        ram_rdata;
    logic [7:0]        old_byte;
    logic [7:0]        new_byte;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              accept;
    logic              issue;
    logic              done;
    logic              out_free;

    always_comb begin
        eff_h = r_height & 7'h78;
        if (eff_h == 7'd0) begin
            eff_h = 7'd8;
        end
        if (eff_h > 7'(MAX_HEIGHT)) begin
            eff_h = 7'(MAX_HEIGHT);
        end
    end

    assign pix_color = (r_act == ACT_BITMAP) ? {1'b0, r_pat[7] ^ r_inv} : r_color;

    pfpp_map #(
        .PANEL_WIDTH(PANEL_WIDTH)
    ) u_map (
        .i_x        (r_x),
        .i_y        (r_y),
        .i_color    (pix_color),
        .i_rotation (r_rotation),
        .i_height   (eff_h),
        .o_loc      (map_loc)
    );

    // The previous cycle's write is not yet visible in the registered read.
    assign old_byte = (r_wb_v && (r_wb_idx == r_s2.idx)) ? r_wb_data : ram_rdata;

    always_comb begin
        case (r_s2.color)
            COL_CLEAR:  new_byte = old_byte & ~r_s2.mask;
            COL_SET:    new_byte = old_byte | r_s2.mask;
            COL_TOGGLE: new_byte = old_byte ^ r_s2.mask;
            default:    new_byte = old_byte;
        endcase
    end

    always_comb begin
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = 8'd0;
        end else begin
            ram_we    = r_s2_v && r_s2.wr;
            ram_waddr = r_s2.idx[ADDR_W-1:0];
            ram_wdata = new_byte;
        end
    end

    pfpp_ram #(
        .WIDTH(8),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_s1.idx[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign issue      = (r_state == ST_RUN) && (r_left != 4'd0);
    assign done       = (r_state == ST_RUN) && (r_left == 4'd0) && !r_s1_v && !r_s2_v;
    assign out_free   = !r_out_v || !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_x     = r_x;
        n_pat   = r_pat;
        n_left  = r_left;
        n_cnt   = r_cnt;
        n_rd    = r_rd;
        n_s1_v  = issue;
        n_s1    = map_loc;
        n_wb_v  = (r_state != ST_CLEAR) && r_s2_v && r_s2.wr;
        n_out_v = r_out_v && i_out_stall;
        n_out   = r_out;

        if (r_act == ACT_READ) begin
            n_s1.wr    = 1'b0;
            n_s1.rd    = 1'b1;
            n_s1.idx   = {{(IDX_W-ADDR_W){1'b0}}, r_addr};
            n_s1.mask  = 8'd0;
            n_s1.color = COL_KEEP;
        end

        case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == ADDR_W'(STORE_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_RUN;
                    n_x     = 17'(i_in_data.x_pos);
                    n_pat   = i_in_data.pattern;
                    n_cnt   = 4'd0;
                    n_rd    = 8'd0;
                    case (i_in_data.action)
                        ACT_PIXEL:  n_left = 4'd1;
                        ACT_BITMAP: n_left = 4'd8;
                        ACT_READ:   n_left = 4'd1;
                        default:    n_left = 4'd0;
                    endcase
                end
            end
            ST_RUN: begin
                if (issue) begin
                    n_x    = r_x + 17'sd1;
                    n_pat  = {r_pat[6:0], 1'b0};
                    n_left = r_left - 4'd1;
                end
                if (r_s2_v && r_s2.wr) begin
                    n_cnt = r_cnt + 4'd1;
                end
                if (r_s2_v && r_s2.rd) begin
                    n_rd = ram_rdata;
                end
                if (done && out_free) begin
                    n_out_v              = 1'b1;
                    n_out.read_data      = r_rd;
                    n_out.pixels_written = r_cnt;
                    n_state              = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr      <= '0;
            r_rotation <= 2'd0;
            r_height   <= HEIGHT_RESET;
            r_left     <= 4'd0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_wb_v     <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_left  <= n_left;
            r_s1_v  <= n_s1_v;
            r_s2_v  <= r_s1_v;
            r_wb_v  <= n_wb_v;
            r_out_v <= n_out_v;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROTATION:     r_rotation <= i_cfg_data[1:0];
                    CFG_PANEL_HEIGHT: r_height   <= i_cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act   <= i_in_data.action;
            r_y     <= i_in_data.y_pos;
            r_color <= i_in_data.color;
            r_inv   <= i_in_data.invert;
            r_addr  <= i_in_data.read_address;
        end
        r_x       <= n_x;
        r_pat     <= n_pat;
        r_cnt     <= n_cnt;
        r_rd      <= n_rd;
        r_s1      <= n_s1;
        r_s2      <= r_s1;
        r_wb_idx  <= r_s2.idx;
        r_wb_data <= new_byte;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule
